@@ sv/kcl_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and constants of the keypad code lock.
// No dependencies; used by every other file of the block.
package kcl_pkg;

    // Lock mode, one-hot
    typedef enum logic [5:0] {
        MODE_CLOSED  = 6'b000001,
        MODE_OPEN    = 6'b000010,
        MODE_DENIED  = 6'b000100,
        MODE_HOURS   = 6'b001000,
        MODE_MINUTES = 6'b010000,
        MODE_SECONDS = 6'b100000
    } kcl_mode_t;

    // Mode codes as shown on the result channel
    localparam logic [2:0] MCODE_CLOSED  = 3'd0;
    localparam logic [2:0] MCODE_OPEN    = 3'd1;
    localparam logic [2:0] MCODE_DENIED  = 3'd2;
    localparam logic [2:0] MCODE_HOURS   = 3'd3;
    localparam logic [2:0] MCODE_MINUTES = 3'd4;
    localparam logic [2:0] MCODE_SECONDS = 3'd5;

    // Time field codes
    localparam logic [1:0] FIELD_NONE    = 2'd0;
    localparam logic [1:0] FIELD_HOURS   = 2'd1;
    localparam logic [1:0] FIELD_MINUTES = 2'd2;
    localparam logic [1:0] FIELD_SECONDS = 2'd3;

    // Key codes
    localparam logic [6:0] KEY_DIGIT_MAX = 7'd9;
    localparam logic [6:0] KEY_A         = 7'd65;
    localparam logic [6:0] KEY_B         = 7'd66;
    localparam logic [6:0] KEY_C         = 7'd67;
    localparam logic [6:0] KEY_HASH      = 7'd35;

    // Configuration register indexes
    localparam logic [2:0] REG_CODE_0       = 3'd0;
    localparam logic [2:0] REG_CODE_1       = 3'd1;
    localparam logic [2:0] REG_CODE_2       = 3'd2;
    localparam logic [2:0] REG_CODE_3       = 3'd3;
    localparam logic [2:0] REG_OPEN_TICKS   = 3'd4;
    localparam logic [2:0] REG_DENIED_TICKS = 3'd5;
    localparam logic [2:0] REG_EDIT_TIMEOUT = 3'd6;

    localparam int         CFG_INDEX_W = 3;
    localparam int         CFG_DATA_W  = 8;

    // Reset values
    localparam logic [7:0] OPEN_TICKS_RST   = 8'd30;
    localparam logic [7:0] DENIED_TICKS_RST = 8'd20;
    localparam logic [7:0] EDIT_TIMEOUT_RST = 8'd250;
    localparam logic [7:0] TICK_RESTART     = 8'd255;
    localparam logic [7:0] TICK_CLOSED_WRAP = 8'd1;

    typedef struct packed {
        logic       key_pressed;
        logic [6:0] key_code;
    } kcl_key_t;

    typedef struct packed {
        logic [2:0] mode;
        logic       message_valid;
        logic [2:0] stars_shown;
        logic       edit_valid;
        logic [3:0] edit_digit;
        logic       edit_position;
        logic       save_valid;
        logic [1:0] time_field;
    } kcl_result_t;

    typedef struct packed {
        logic [3:0][3:0] code;
        logic [7:0]      open_ticks;
        logic [7:0]      denied_ticks;
        logic [7:0]      edit_timeout_ticks;
    } kcl_cfg_t;

    // Control state carried between ticks
    typedef struct packed {
        kcl_mode_t  mode;
        logic [7:0] tick;
        logic       edit_pos;
    } kcl_state_t;

endpackage

@@ sv/kcl_if.sv @@
`timescale 1ns / 1ps
// Valid/ready channel interfaces for key ticks and lock results.
// Depends on kcl_pkg for the payload types.
interface kcl_key_if ();
    logic              valid;
    logic              ready;
    kcl_pkg::kcl_key_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface kcl_result_if ();
    logic                 valid;
    logic                 ready;
    kcl_pkg::kcl_result_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

@@ sv/kcl_step.sv @@
`timescale 1ns / 1ps
// Next-state and result logic for one tick of the code lock.
// Depends on kcl_pkg.
module kcl_step #(
    parameter int CODE_LENGTH = 4,
    parameter int CNT_W       = $clog2(CODE_LENGTH + 1)
) (
    input  kcl_pkg::kcl_cfg_t    cfg,
    input  kcl_pkg::kcl_state_t  state,
    input  logic [CNT_W-1:0]     cnt,
    input  logic [3:0]           digits [CODE_LENGTH],
    input  kcl_pkg::kcl_key_t    key,
    output kcl_pkg::kcl_state_t  state_next,
    output logic [CNT_W-1:0]     cnt_next,
    output logic [CODE_LENGTH-1:0] wr_en,
    output kcl_pkg::kcl_result_t result
);

    logic [7:0] tick;
    logic       is_digit;
    logic       match;
    logic       left;
    logic [6:0] save_key;
    logic [7:0] limit;

    assign tick     = state.tick + 8'd1;
    assign is_digit = key.key_code <= kcl_pkg::KEY_DIGIT_MAX;

    // Entered code against configured digits; positions past four want zero
    always_comb
    begin
        match = 1'b1;
        for (int i = 0; i < CODE_LENGTH; i++)
        begin
            if (i < 4)
            begin
                if (digits[i] != cfg.code[2'(i)])
                    match = 1'b0;
            end
            else if (digits[i] != 4'd0)
            begin
                match = 1'b0;
            end
        end
    end

    always_comb
    begin
        state_next           = state;
        state_next.tick      = tick;
        cnt_next             = cnt;
        wr_en                = '0;
        left                 = 1'b0;
        save_key             = kcl_pkg::KEY_A;
        limit                = cfg.open_ticks;
        result               = '0;
        result.message_valid = (tick == 8'd0);

        unique case (state.mode) inside
            kcl_pkg::MODE_OPEN, kcl_pkg::MODE_DENIED:
            begin
                if (state.mode == kcl_pkg::MODE_OPEN)
                begin
                    result.mode = kcl_pkg::MCODE_OPEN;
                    limit       = cfg.open_ticks;
                end
                else
                begin
                    result.mode = kcl_pkg::MCODE_DENIED;
                    limit       = cfg.denied_ticks;
                end
                if (tick == 8'd0)
                    cnt_next = '0;
                if (tick == limit)
                begin
                    state_next.mode = kcl_pkg::MODE_CLOSED;
                    state_next.tick = kcl_pkg::TICK_RESTART;
                end
            end
            kcl_pkg::MODE_HOURS, kcl_pkg::MODE_MINUTES, kcl_pkg::MODE_SECONDS:
            begin
                if (state.mode == kcl_pkg::MODE_HOURS)
                begin
                    result.mode       = kcl_pkg::MCODE_HOURS;
                    result.time_field = kcl_pkg::FIELD_HOURS;
                    save_key          = kcl_pkg::KEY_A;
                end
                else if (state.mode == kcl_pkg::MODE_MINUTES)
                begin
                    result.mode       = kcl_pkg::MCODE_MINUTES;
                    result.time_field = kcl_pkg::FIELD_MINUTES;
                    save_key          = kcl_pkg::KEY_B;
                end
                else
                begin
                    result.mode       = kcl_pkg::MCODE_SECONDS;
                    result.time_field = kcl_pkg::FIELD_SECONDS;
                    save_key          = kcl_pkg::KEY_C;
                end
                if (tick == 8'd0)
                    cnt_next = '0;
                if (key.key_pressed)
                begin
                    if (is_digit)
                    begin
                        result.edit_valid    = 1'b1;
                        result.edit_digit    = key.key_code[3:0];
                        result.edit_position = state.edit_pos;
                        state_next.edit_pos  = ~state.edit_pos;
                    end
                    else if (key.key_code == save_key)
                    begin
                        result.save_valid = 1'b1;
                        left              = 1'b1;
                    end
                    else if (key.key_code == kcl_pkg::KEY_HASH)
                    begin
                        left = 1'b1;
                    end
                end
                if (left || tick == cfg.edit_timeout_ticks)
                begin
                    state_next.mode = kcl_pkg::MODE_CLOSED;
                    state_next.tick = kcl_pkg::TICK_RESTART;
                end
            end
            default:
            begin
                // closed; also recovers any illegal code
                result.mode     = kcl_pkg::MCODE_CLOSED;
                state_next.mode = kcl_pkg::MODE_CLOSED;
                if (tick == 8'd255)
                    state_next.tick = kcl_pkg::TICK_CLOSED_WRAP;
                if (cnt == CNT_W'(CODE_LENGTH))
                begin
                    // evaluation tick: any key is dropped
                    state_next.mode = match ? kcl_pkg::MODE_OPEN : kcl_pkg::MODE_DENIED;
                    state_next.tick = kcl_pkg::TICK_RESTART;
                end
                else if (key.key_pressed)
                begin
                    if (key.key_code == kcl_pkg::KEY_A)
                    begin
                        state_next.mode = kcl_pkg::MODE_HOURS;
                        state_next.tick = kcl_pkg::TICK_RESTART;
                    end
                    else if (key.key_code == kcl_pkg::KEY_B)
                    begin
                        state_next.mode = kcl_pkg::MODE_MINUTES;
                        state_next.tick = kcl_pkg::TICK_RESTART;
                    end
                    else if (key.key_code == kcl_pkg::KEY_C)
                    begin
                        state_next.mode = kcl_pkg::MODE_SECONDS;
                        state_next.tick = kcl_pkg::TICK_RESTART;
                    end
                    else if (is_digit)
                    begin
                        for (int i = 0; i < CODE_LENGTH; i++)
                        begin
                            if (cnt == CNT_W'(i))
                                wr_en[i] = 1'b1;
                        end
                        cnt_next = cnt + CNT_W'(1);
                    end
                end
            end
        endcase

        result.stars_shown = 3'(cnt_next);
    end

endmodule

@@ sv/keypad_code_lock_fsm_unit.sv @@
`timescale 1ns / 1ps
// Keypad code lock, top level: channel pipeline, registers, digit store.
// Depends on kcl_pkg, kcl_if.sv and kcl_step.
//
// Usage
//   keys    : one transfer per tick; key_pressed marks a key, key_code is
//             0..9 for digits, ASCII for A-D, '#', '*'.
//   results : exactly one transfer per key transfer, in order, describing
//             the tick just handled (mode, message, stars, edit/save events).
//   cfg     : cfg_we writes cfg_data into register cfg_index (0..3 code
//             digits, 4 open ticks, 5 denied ticks, 6 edit timeout); other
//             indexes are dropped. Write only while no tick is in flight.
// Timing
//   Two register stages: the input register, then the result register,
//   which also holds the lock state update. A key transfer fills the input
//   register, its result then the result register. One tick per cycle is
//   sustained while results.ready is high; the single state update sets it.
// Reset
//   rst_n clears both stages, the lock to closed with the tick counter at
//   255, no digits entered, edit position 0, registers to their defaults.
// Stalls
//   While a result waits with results.ready low, the result register holds;
//   an empty input register still takes one more tick, then keys.ready drops.
module keypad_code_lock_fsm_unit #(
    parameter int CODE_LENGTH = 4
) (
    input  logic                            clk,
    input  logic                            rst_n,
    kcl_key_if.sink                         keys,
    kcl_result_if.source                    results,
    input  logic                            cfg_we,
    input  logic [kcl_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [kcl_pkg::CFG_DATA_W-1:0]  cfg_data
);

    localparam int CNT_W = $clog2(CODE_LENGTH + 1);

    kcl_pkg::kcl_cfg_t    cfg_reg;
    kcl_pkg::kcl_state_t  state_reg;
    kcl_pkg::kcl_state_t  state_next;
    logic [CNT_W-1:0]     cnt_reg;
    logic [CNT_W-1:0]     cnt_next;
    logic [3:0]           digits_reg [CODE_LENGTH];
    logic [CODE_LENGTH-1:0] wr_en;

    logic                 in_valid_reg;
    kcl_pkg::kcl_key_t    in_data_reg;
    logic                 out_valid_reg;
    kcl_pkg::kcl_result_t out_data_reg;
    kcl_pkg::kcl_result_t result;
    logic                 step_go;

    // Stage 1 advances when the result register is free or being drained
    assign step_go    = in_valid_reg && (!out_valid_reg || results.ready);
    assign keys.ready = !in_valid_reg || step_go;

    assign results.valid = out_valid_reg;
    assign results.data  = out_data_reg;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.code               <= '0;
            cfg_reg.open_ticks         <= kcl_pkg::OPEN_TICKS_RST;
            cfg_reg.denied_ticks       <= kcl_pkg::DENIED_TICKS_RST;
            cfg_reg.edit_timeout_ticks <= kcl_pkg::EDIT_TIMEOUT_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                kcl_pkg::REG_CODE_0:       cfg_reg.code[0] <= cfg_data[3:0];
                kcl_pkg::REG_CODE_1:       cfg_reg.code[1] <= cfg_data[3:0];
                kcl_pkg::REG_CODE_2:       cfg_reg.code[2] <= cfg_data[3:0];
                kcl_pkg::REG_CODE_3:       cfg_reg.code[3] <= cfg_data[3:0];
                kcl_pkg::REG_OPEN_TICKS:   cfg_reg.open_ticks <= cfg_data;
                kcl_pkg::REG_DENIED_TICKS: cfg_reg.denied_ticks <= cfg_data;
                kcl_pkg::REG_EDIT_TIMEOUT: cfg_reg.edit_timeout_ticks <= cfg_data;
                default:                   ;
            endcase
        end
    end

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (keys.ready)
            in_valid_reg <= keys.valid;
    end

    always_ff @(posedge clk)
    begin
        if (keys.valid && keys.ready)
            in_data_reg <= keys.data;
    end

    kcl_step #(
        .CODE_LENGTH (CODE_LENGTH),
        .CNT_W       (CNT_W)
    ) u_step (
        .cfg        (cfg_reg),
        .state      (state_reg),
        .cnt        (cnt_reg),
        .digits     (digits_reg),
        .key        (in_data_reg),
        .state_next (state_next),
        .cnt_next   (cnt_next),
        .wr_en      (wr_en),
        .result     (result)
    );

    // Lock state, updated together with the result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.mode     <= kcl_pkg::MODE_CLOSED;
            state_reg.tick     <= kcl_pkg::TICK_RESTART;
            state_reg.edit_pos <= 1'b0;
            cnt_reg            <= '0;
        end
        else if (step_go)
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    // Entered digits: every entry is written before the code compare reads it
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < CODE_LENGTH; i++)
        begin
            if (step_go && wr_en[i])
                digits_reg[i] <= in_data_reg.key_code[3:0];
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (step_go)
            out_valid_reg <= 1'b1;
        else if (results.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (step_go)
            out_data_reg <= result;
    end

endmodule

@@ sv/kcl_checker.sv @@
`timescale 1ns / 1ps
// Port-level checks for the keypad code lock, bound to the top level.
// Depends on kcl_pkg and keypad_code_lock_fsm_unit.
module kcl_checker (
    input logic                 clk,
    input logic                 rst_n,
    input logic                 in_ready,
    input logic                 out_valid,
    input logic                 out_ready,
    input kcl_pkg::kcl_result_t out_data
);

    // Held result does not change under a stall
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(out_data))
        else $error("result changed while stalled");

    // An empty result register never blocks the key channel
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("keys stalled with empty result register");

    // Edit and save events only come from an edit mode with its own field
    a_edit: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_data.edit_valid || out_data.save_valid) |->
            (out_data.mode == kcl_pkg::MCODE_HOURS
                && out_data.time_field == kcl_pkg::FIELD_HOURS)
            || (out_data.mode == kcl_pkg::MCODE_MINUTES
                && out_data.time_field == kcl_pkg::FIELD_MINUTES)
            || (out_data.mode == kcl_pkg::MCODE_SECONDS
                && out_data.time_field == kcl_pkg::FIELD_SECONDS))
        else $error("edit event outside its edit mode");

    // Entering open clears the entered digits
    a_clear: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.message_valid && out_data.mode == kcl_pkg::MCODE_OPEN
            |-> out_data.stars_shown == 3'd0)
        else $error("digits not cleared on open");

endmodule

bind keypad_code_lock_fsm_unit kcl_checker u_kcl_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ready  (keys.ready),
    .out_valid (results.valid),
    .out_ready (results.ready),
    .out_data  (results.data)
);
